>>> sv/clf_pkg.sv
// Shared types and constants for the reclaim client classifier table.
// Holds class codes, command word layout and default sizes.
// No dependencies.
package clf_pkg;

	localparam int CLF_TABLE_ENTRIES = 64;
	localparam int CLF_QUEUE_DEPTH   = 2;
	localparam int CLF_CFG_WIDTH     = 16;
	localparam int CLF_CFG_IDX_WIDTH = 2;

	// Configuration register indexes.
	localparam logic [CLF_CFG_IDX_WIDTH-1:0] REG_SPLIT_ENABLE = 2'd0;
	localparam logic [CLF_CFG_IDX_WIDTH-1:0] REG_DEBUG_SKIP   = 2'd1;
	localparam logic [CLF_CFG_IDX_WIDTH-1:0] REG_HOT_THRESH   = 2'd2;
	localparam logic [CLF_CFG_IDX_WIDTH-1:0] REG_DEFAULT_COST = 2'd3;

	// Client class codes.
	localparam logic [2:0] CLS_COLD  = 3'd0;
	localparam logic [2:0] CLS_ZERO  = 3'd1;
	localparam logic [2:0] CLS_DEF   = 3'd2;
	localparam logic [2:0] CLS_HOT   = 3'd3;
	localparam logic [2:0] CLS_DELAY = 3'd4;
	localparam logic [2:0] CLS_SKIP  = 3'd5;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_DIRECT,
		OP_LOOKUP,
		OP_DEREG
	} op_t;

	// Classified word passed from the front end to the table engine.
	typedef struct packed {
		op_t         op;
		logic [63:0] key;
		logic [15:0] cost;
		logic [2:0]  cls;
		logic        listed;
	} cmd_t;

endpackage

>>> sv/clf_front.sv
// Front end: accepts input words and classifies them into commands.
// Resolves every case that needs no table access. Depends on clf_pkg.
module clf_front import clf_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [63:0] client_key,
	input  logic [15:0] reclaim_cost,
	input  logic [5:0]  preset_class,
	input  logic        split_enable,
	input  logic        debug_skip_enable,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	function automatic logic [2:0] lowest_class(input logic [5:0] mask);
		logic [2:0] c;
		c = CLS_COLD;
		for (int b = 5; b >= 0; b--) begin
			if (mask[b]) begin
				c = 3'(b);
			end
		end
		return c;
	endfunction

	logic [2:0] low_cls;

	assign low_cls  = lowest_class(preset_class);
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.key    = client_key;
		q_cmd.cost   = reclaim_cost;
		q_cmd.cls    = low_cls;
		q_cmd.listed = 1'b1;
		q_cmd.op     = OP_DIRECT;
		if (action) begin
			q_cmd.op     = OP_DEREG;
			q_cmd.listed = 1'b0;
		end else if (!split_enable) begin
			q_cmd.cls = CLS_COLD;
		end else if (preset_class != 6'd0) begin
			q_cmd.listed = !(low_cls == CLS_SKIP && !debug_skip_enable);
		end else begin
			q_cmd.op = OP_LOOKUP;
		end
	end

endmodule

>>> sv/clf_fifo.sv
// Short command queue between the front end and the table engine.
// Depends on clf_pkg for the command word and the queue depth.
module clf_fifo import clf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t pop_cmd
);

	localparam int PW = (CLF_QUEUE_DEPTH > 1) ? $clog2(CLF_QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(CLF_QUEUE_DEPTH + 1);

	cmd_t          slot_q [CLF_QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(CLF_QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_cmd   = slot_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(CLF_QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> sv/clf_back.sv
// Table engine: scans the key memory, updates counts, inserts new keys,
// and holds the result word for the output channel. Depends on clf_pkg.
module clf_back import clf_pkg::*; #(
	parameter int TABLE_ENTRIES = CLF_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	input  logic [15:0] hot_threshold,
	input  logic [15:0] default_cost,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  client_class,
	output logic        listed,
	output logic [15:0] use_count,
	output logic        key_found,
	output logic        table_full
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] issue_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [15:0]   hit_cnt_q;

	logic          rd_vld_s1;
	logic [IW-1:0] idx_s1;
	logic [63:0]   key_rd_s1;
	logic [15:0]   cnt_rd_s1;

	logic [63:0]   key_mem [TABLE_ENTRIES];
	logic [15:0]   cnt_mem [TABLE_ENTRIES];

	logic          issuing;
	logic          match;
	logic          out_free;
	logic          finish;
	logic          has_room;
	logic          ins_we;
	logic          cnt_we;
	logic [IW-1:0] cnt_addr;
	logic [15:0]   cnt_wdata;
	logic [15:0]   inc_cnt;
	logic [15:0]   res_count;
	logic [2:0]    res_cls;
	logic          res_found;
	logic          res_full;

	assign issuing  = issue_q < fill_q;
	assign match    = rd_vld_s1 && (key_rd_s1 == cmd_q.key);
	assign out_free = !out_valid || out_ready;
	assign finish   = (state_q == ST_RESOLVE) && out_free;
	assign has_room = fill_q < CW'(TABLE_ENTRIES);
	assign q_pop    = (state_q == ST_IDLE) && q_not_empty;
	assign inc_cnt  = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 16'd1;

	// A register miss takes a free slot; a deregister hit bumps its count.
	assign ins_we    = finish && cmd_q.op == OP_LOOKUP && !hit_q && has_room;
	assign cnt_we    = ins_we || (finish && cmd_q.op == OP_DEREG && hit_q);
	assign cnt_addr  = ins_we ? fill_q[IW-1:0] : hit_idx_q;
	assign cnt_wdata = ins_we ? 16'd0 : inc_cnt;

	always_comb begin
		res_cls   = cmd_q.cls;
		res_count = 16'd0;
		res_found = hit_q;
		res_full  = 1'b0;
		unique case (cmd_q.op)
			OP_DIRECT: begin
				res_found = 1'b0;
			end
			OP_DEREG: begin
				res_count = hit_q ? inc_cnt : 16'd0;
			end
			OP_LOOKUP: begin
				res_count = hit_q ? hit_cnt_q : 16'd0;
				res_full  = !hit_q && !has_room;
				if (res_count >= hot_threshold) begin
					res_cls = CLS_HOT;
				end else if (cmd_q.cost == default_cost) begin
					res_cls = CLS_DEF;
				end else if (cmd_q.cost == 16'd0) begin
					res_cls = CLS_ZERO;
				end else begin
					res_cls = CLS_COLD;
				end
			end
			default: begin
				res_found = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_rd_s1 <= key_mem[issue_q[IW-1:0]];
		cnt_rd_s1 <= cnt_mem[issue_q[IW-1:0]];
		if (ins_we) begin
			key_mem[fill_q[IW-1:0]] <= cmd_q.key;
		end
		if (cnt_we) begin
			cnt_mem[cnt_addr] <= cnt_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			issue_q      <= '0;
			hit_q        <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_valid    <= 1'b0;
			cmd_q        <= '0;
			hit_idx_q    <= '0;
			hit_cnt_q    <= '0;
			idx_s1       <= '0;
			client_class <= CLS_COLD;
			listed       <= 1'b0;
			use_count    <= '0;
			key_found    <= 1'b0;
			table_full   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && issuing && !match;
			idx_s1    <= issue_q[IW-1:0];
			if (out_valid && out_ready && !finish) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_not_empty) begin
						cmd_q   <= q_cmd;
						hit_q   <= 1'b0;
						issue_q <= '0;
						state_q <= (q_cmd.op == OP_DIRECT) ? ST_RESOLVE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + CW'(1);
					end
					if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
						hit_cnt_q <= cnt_rd_s1;
						state_q   <= ST_RESOLVE;
					end else if (!issuing && !rd_vld_s1) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						client_class <= res_cls;
						listed       <= cmd_q.listed;
						use_count    <= res_count;
						key_found    <= res_found;
						table_full   <= res_full;
						if (ins_we) begin
							fill_q <= fill_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_ENTRIES))
		else $error("fill level beyond table size");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + CW'(1))
		else $error("fill level moved by more than one slot");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == ST_SCAN))
		else $error("table read outside of a scan");

	a_result_from_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_RESOLVE))
		else $error("result word loaded outside of resolve");
`endif

endmodule

>>> sv/reclaim_client_classifier_table.sv
// Top level of the reclaim client classifier table.
// Holds the configuration registers and joins clf_front, clf_fifo and clf_back.
// Depends on clf_pkg.
//
//   channel  handshake             payload
//   in       in_valid / in_ready    action, client_key, reclaim_cost, preset_class
//   out      out_valid / out_ready  client_class, listed, use_count, key_found, table_full
//   cfg      cfg_we                 cfg_index, cfg_data
//
// A word that needs no table access skips the scan and goes straight to the result.
// A table lookup scans the filled entries with one key memory read per cycle,
// stopping at the first match or after the last filled entry.
// The front end keeps accepting words into a two-entry queue, until it fills, while
// the table engine is busy or a result waits on a stalled output.
// Reset clears the fill level and queue; no clearing pass is needed.
module reclaim_client_classifier_table import clf_pkg::*; #(
	parameter int TABLE_ENTRIES = CLF_TABLE_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [63:0]                  client_key,
	input  logic [15:0]                  reclaim_cost,
	input  logic [5:0]                   preset_class,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   client_class,
	output logic                         listed,
	output logic [15:0]                  use_count,
	output logic                         key_found,
	output logic                         table_full,
	input  logic                         cfg_we,
	input  logic [CLF_CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [CLF_CFG_WIDTH-1:0]     cfg_data
);

	logic        split_q;
	logic        dbg_skip_q;
	logic [15:0] hot_thresh_q;
	logic [15:0] def_cost_q;

	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_not_empty;
	cmd_t        push_cmd;
	cmd_t        pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q      <= 1'b1;
			dbg_skip_q   <= 1'b0;
			hot_thresh_q <= 16'd30;
			def_cost_q   <= 16'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPLIT_ENABLE: split_q      <= cfg_data[0];
				REG_DEBUG_SKIP:   dbg_skip_q   <= cfg_data[0];
				REG_HOT_THRESH:   hot_thresh_q <= cfg_data[15:0];
				REG_DEFAULT_COST: def_cost_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	clf_front u_front (
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.client_key        (client_key),
		.reclaim_cost      (reclaim_cost),
		.preset_class      (preset_class),
		.split_enable      (split_q),
		.debug_skip_enable (dbg_skip_q),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_cmd             (push_cmd)
	);

	clf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_cmd   (pop_cmd)
	);

	clf_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_cmd         (pop_cmd),
		.q_pop         (q_pop),
		.hot_threshold (hot_thresh_q),
		.default_cost  (def_cost_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.client_class  (client_class),
		.listed        (listed),
		.use_count     (use_count),
		.key_found     (key_found),
		.table_full    (table_full)
	);

endmodule

>>> tb/reclaim_client_classifier_table_checker.sv
// Scoreboard for the reclaim client classifier table: watches the input, output
// and register ports, predicts each result from its own copy of the table and
// compares field by field. Depends on clf_pkg.
`timescale 1ns / 1ps

module reclaim_client_classifier_table_checker import clf_pkg::*; #(
	parameter int   TABLE_ENTRIES = CLF_TABLE_ENTRIES,
	parameter logic DEREG_ACTION  = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         action,
	input  logic [63:0]                  client_key,
	input  logic [15:0]                  reclaim_cost,
	input  logic [5:0]                   preset_class,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [2:0]                   client_class,
	input  logic                         listed,
	input  logic [15:0]                  use_count,
	input  logic                         key_found,
	input  logic                         table_full,
	input  logic                         cfg_we,
	input  logic [CLF_CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [CLF_CFG_WIDTH-1:0]     cfg_data,
	output int                           fail_count,
	output int                           outstanding
);

	typedef struct packed {
		logic [2:0]  cls;
		logic        listed;
		logic [15:0] uses;
		logic        found;
		logic        full;
	} client_result_t;

	logic [63:0]    slot_key  [TABLE_ENTRIES];
	logic [15:0]    slot_uses [TABLE_ENTRIES];
	int             slots_used;
	logic           split_on;
	logic           skip_listed;
	logic [15:0]    hot_level;
	logic [15:0]    default_seek_cost;
	client_result_t pending_results[$];

	// Class codes follow the bit positions of the preset mask.
	function automatic logic [2:0] first_class(input logic [5:0] mask);
		for (int b = 0; b < 6; b++) begin
			if (mask[b])
				return 3'(b);
		end
		return CLS_COLD;
	endfunction

	function automatic int find_key(input logic [63:0] key);
		for (int i = 0; i < slots_used; i++) begin
			if (slot_key[i] == key)
				return i;
		end
		return -1;
	endfunction

	function automatic client_result_t classify(input logic act, input logic [63:0] key,
			input logic [15:0] cost, input logic [5:0] preset);
		client_result_t r;
		int slot;
		r = '0;
		if (act == DEREG_ACTION) begin
			r.cls = first_class(preset);
			slot = find_key(key);
			if (slot >= 0) begin
				if (slot_uses[slot] != COUNT_MAX)
					slot_uses[slot] = slot_uses[slot] + 16'd1;
				r.uses = slot_uses[slot];
				r.found = 1'b1;
			end
		end else begin
			if (!split_on) begin
				r.cls = CLS_COLD;
			end else if (preset != '0) begin
				r.cls = first_class(preset);
			end else begin
				slot = find_key(key);
				if (slot >= 0) begin
					r.uses = slot_uses[slot];
					r.found = 1'b1;
				end else if (slots_used < TABLE_ENTRIES) begin
					slot_key[slots_used] = key;
					slot_uses[slots_used] = '0;
					slots_used++;
				end else begin
					r.full = 1'b1;
				end
				if (r.uses >= hot_level)
					r.cls = CLS_HOT;
				else if (cost == default_seek_cost)
					r.cls = CLS_DEF;
				else if (cost == '0)
					r.cls = CLS_ZERO;
				else
					r.cls = CLS_COLD;
			end
			r.listed = !(r.cls == CLS_SKIP && !skip_listed);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		client_result_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			slots_used = 0;
			split_on = 1'b1;
			skip_listed = 1'b0;
			hot_level = 16'd30;
			default_seek_cost = 16'd2;
			pending_results.delete();
		end else begin
			// Results are checked before new words are predicted, so a word
			// accepted at this edge can never match a result at the same edge.
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word: class %0d, count %0d", client_class,
						use_count);
					errs++;
				end else begin
					want = pending_results.pop_front();
					if (client_class !== want.cls) begin
						$error("client_class: expected %0d, actual %0d", want.cls, client_class);
						errs++;
					end
					if (listed !== want.listed) begin
						$error("listed: expected %0d, actual %0d", want.listed, listed);
						errs++;
					end
					if (use_count !== want.uses) begin
						$error("use_count: expected %0d, actual %0d", want.uses, use_count);
						errs++;
					end
					if (key_found !== want.found) begin
						$error("key_found: expected %0d, actual %0d", want.found, key_found);
						errs++;
					end
					if (table_full !== want.full) begin
						$error("table_full: expected %0d, actual %0d", want.full, table_full);
						errs++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SPLIT_ENABLE: split_on = cfg_data[0];
					REG_DEBUG_SKIP:   skip_listed = cfg_data[0];
					REG_HOT_THRESH:   hot_level = cfg_data;
					REG_DEFAULT_COST: default_seek_cost = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_results.push_back(classify(action, client_key, reclaim_cost,
					preset_class));
		end
		fail_count <= fail_count + errs;
		outstanding <= pending_results.size();
	end

endmodule

>>> tb/reclaim_client_classifier_table_tb.sv
// Top of the reclaim client classifier table testbench: clock, reset, stimulus,
// register phases and the verdict. Depends on clf_pkg, the block and
// reclaim_client_classifier_table_checker.
`timescale 1ns / 1ps

module reclaim_client_classifier_table_tb;
	import clf_pkg::*;

	localparam logic ACT_REGISTER   = 1'b0;
	localparam logic ACT_DEREGISTER = 1'b1;

	localparam int KEY_POOL       = 80;
	localparam int IDLE_PCT       = 9;
	localparam int HOLD_CYCLES    = 400;
	localparam int STALL_LIMIT    = 5000;
	localparam int RANDOM_WORDS   = 900;
	localparam int PHASES         = 8;
	localparam int SETTLE_CYCLES  = 100;
	localparam int HOT_WORDS      = 40;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         action;
	logic [63:0]                  client_key;
	logic [15:0]                  reclaim_cost;
	logic [5:0]                   preset_class;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [2:0]                   client_class;
	logic                         listed;
	logic [15:0]                  use_count;
	logic                         key_found;
	logic                         table_full;
	logic                         cfg_we;
	logic [CLF_CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CLF_CFG_WIDTH-1:0]     cfg_data;

	int          fail_count;
	int          outstanding;
	int          quiet_cycles;
	int          hold_left;
	logic        hold_done = 1'b0;
	logic        hold_req;
	logic        calm;
	logic [15:0] cur_default_cost;
	logic [63:0] key_pool [KEY_POOL];

	reclaim_client_classifier_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.client_key   (client_key),
		.reclaim_cost (reclaim_cost),
		.preset_class (preset_class),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.client_class (client_class),
		.listed       (listed),
		.use_count    (use_count),
		.key_found    (key_found),
		.table_full   (table_full),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	reclaim_client_classifier_table_checker #(
		.DEREG_ACTION (ACT_DEREGISTER)
	) scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.client_key   (client_key),
		.reclaim_cost (reclaim_cost),
		.preset_class (preset_class),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.client_class (client_class),
		.listed       (listed),
		.use_count    (use_count),
		.key_found    (key_found),
		.table_full   (table_full),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off so the input backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic send_word(input logic act, input logic [63:0] key,
			input logic [15:0] cost, input logic [5:0] preset);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		client_key <= key;
		reclaim_cost <= cost;
		preset_class <= preset;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CLF_CFG_IDX_WIDTH-1:0] idx,
			input logic [CLF_CFG_WIDTH-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic write_regs(input logic split, input logic dbg, input logic [15:0] thr,
			input logic [15:0] dcost);
		wait_empty();
		write_reg(REG_SPLIT_ENABLE, 16'(split));
		write_reg(REG_DEBUG_SKIP, 16'(dbg));
		write_reg(REG_HOT_THRESH, thr);
		write_reg(REG_DEFAULT_COST, dcost);
		cfg_we <= 1'b0;
		cur_default_cost = dcost;
	endtask

	// Mostly known clients registering and leaving, with some unknown keys mixed in.
	task automatic send_random();
		logic        act;
		logic [63:0] key;
		logic [15:0] cost;
		logic [5:0]  preset;
		act = ($urandom_range(0, 99) < 40) ? ACT_DEREGISTER : ACT_REGISTER;
		if ($urandom_range(0, 99) < 85)
			key = key_pool[$urandom_range(0, KEY_POOL - 1)];
		else
			key = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: cost = '0;
			1: cost = cur_default_cost;
			2: cost = 16'hFFFF;
			3: cost = 16'($urandom_range(1, 8));
			default: cost = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: preset = '0;
			6: preset = 6'h20;
			default: preset = 6'($urandom);
		endcase
		send_word(act, key, cost, preset);
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_REGISTER;
		client_key = '0;
		reclaim_cost = '0;
		preset_class = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SPLIT_ENABLE;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		cur_default_cost = 16'd2;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Push one client's count past the hot threshold while the table is tiny,
		// so each lookup stays short. No idling on either side here.
		calm <= 1'b1;
		send_word(ACT_REGISTER, '0, 16'd5, '0);
		repeat (HOT_WORDS)
			send_word(ACT_DEREGISTER, '0, 16'($urandom), 6'($urandom));
		calm <= 1'b0;

		send_word(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, '0);
		send_word(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2, '0);
		send_word(ACT_REGISTER, 64'h5555_5555_5555_5555, 16'hFFFF, '0);
		send_word(ACT_DEREGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, '0);
		send_word(ACT_DEREGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFF, 6'h3F);
		send_word(ACT_DEREGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'd9, 6'h20);
		for (int b = 0; b < 6; b++)
			send_word(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 6'(1 << b));
		send_word(ACT_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 16'd3, 6'h3F);
		send_word(ACT_REGISTER, 64'h0123_4567_89AB_CDEF, 16'd3, 6'h30);
		send_word(ACT_REGISTER, '0, 16'd1, '0);

		// Skip clients listed, and a zero default cost.
		write_regs(1'b1, 1'b1, 16'd30, 16'd0);
		send_word(ACT_REGISTER, 64'h0123_4567_89AB_CDEF, 16'd1, 6'h20);
		send_word(ACT_REGISTER, 64'h1234_5678_9ABC_DEF0, 16'd0, '0);

		// Splitting off: registration leaves the table alone, deregistration does not.
		write_regs(1'b0, 1'b0, 16'hFFFF, 16'd2);
		send_word(ACT_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 16'd2, 6'h20);
		send_word(ACT_REGISTER, 64'hDEAD_BEEF_CAFE_F00D, 16'd0, '0);
		send_word(ACT_DEREGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, '0);
		send_word(ACT_REGISTER, '0, 16'd2, '0);

		write_regs(1'b1, 1'b0, 16'hFFFF, 16'd2);
		send_word(ACT_REGISTER, '0, 16'd7, '0);
		send_word(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'd7, '0);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_regs(1'b1, 1'b0, 16'd30, 16'd2);
				1: write_regs(1'b1, 1'b1, 16'd3, 16'd0);
				2: write_regs(1'b0, 1'b1, 16'd0, 16'hFFFF);
				3: write_regs(1'b1, 1'b0, 16'd0, 16'd7);
				4: write_regs(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
				5: write_regs(1'b1, 1'b0, 16'd2, 16'($urandom));
				6: write_regs(1'b0, 1'b0, 16'($urandom), 16'($urandom));
				default: write_regs(1'b1, 1'b1, 16'd5, 16'd1);
			endcase
			if (phase == 1)
				hold_req <= 1'b1;
			if (phase == 3)
				calm <= 1'b1;
			if (phase == 4)
				calm <= 1'b0;
			for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
				// Sender pauses mid-phase until the block has drained completely.
				if (phase == 5 && n == 50)
					wait_empty();
				send_random();
			end
		end

		wait_empty();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
